// File: hdl/tsr_pkg.sv
package tsr_pkg;

  typedef enum logic [1:0] {
    FUNC_PUSH   = 2'd0,
    FUNC_POP    = 2'd1,
    FUNC_REMOVE = 2'd2,
    FUNC_NONE   = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_SEARCH,
    S_SHIFT
  } state_t;

endpackage

// File: hdl/tsr_ram.sv
module tsr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 64,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: hdl/tag_stack_with_remove_top.sv
// Channel   Ports                             Handshake
// --------  --------------------------------  ------------------------------------
// command   func, tag                         taken when start is high, busy low
// result    status, out_tag, depth_now        valid for one cycle while done high
//
// Push completes from idle; pop returns the top entry from S_POP. Remove searches
// from the top in S_SEARCH, then moves each entry above the match down in S_SHIFT
// one at a time, as the store has a single read and a single write port.
// The result appears the cycle after the transaction completes.
// Reset empties the stack at once; stored tags are not cleared.
// The receiver cannot stall; busy holds off new commands.
module tag_stack_with_remove_top #(
  parameter int DEPTH    = 64,
  parameter int TAG_BITS = 16,
  localparam int AW = $clog2(DEPTH),
  localparam int CW = $clog2(DEPTH + 1)
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  output logic                busy,
  input  logic [1:0]          func,
  input  logic [TAG_BITS-1:0] tag,
  output logic                done,
  output logic [1:0]          status,
  output logic [TAG_BITS-1:0] out_tag,
  output logic [CW-1:0]       depth_now
);

  tsr_pkg::state_t state, state_next;

  logic [CW-1:0]       count, count_next;
  logic [TAG_BITS-1:0] key, key_next;
  logic [AW-1:0]       ridx, ridx_next;
  logic [AW-1:0]       widx, widx_next;
  logic                done_next;
  logic [1:0]          status_next;
  logic [TAG_BITS-1:0] out_tag_next;
  logic [CW-1:0]       depth_now_next;

  logic                we;
  logic [AW-1:0]       waddr;
  logic [TAG_BITS-1:0] wdata;
  logic [AW-1:0]       raddr;
  logic [TAG_BITS-1:0] rdata;

  logic [CW-1:0]       ridx_up;
  logic [CW-1:0]       widx_up2;
  logic [CW-1:0]       count_dn;

  tsr_ram #(
    .WIDTH (TAG_BITS),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  assign busy     = (state != tsr_pkg::S_IDLE);
  assign ridx_up  = CW'(ridx) + CW'(1);
  assign widx_up2 = CW'(widx) + CW'(2);
  assign count_dn = count - CW'(1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= tsr_pkg::S_IDLE;
      count     <= '0;
      done      <= 1'b0;
      status    <= tsr_pkg::ST_OK;
      out_tag   <= '0;
      depth_now <= '0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      done      <= done_next;
      status    <= status_next;
      out_tag   <= out_tag_next;
      depth_now <= depth_now_next;
    end
    key  <= key_next;
    ridx <= ridx_next;
    widx <= widx_next;
  end

  always_comb begin
    state_next     = state;
    count_next     = count;
    key_next       = key;
    ridx_next      = ridx;
    widx_next      = widx;
    done_next      = 1'b0;
    status_next    = status;
    out_tag_next   = out_tag;
    depth_now_next = depth_now;
    we             = 1'b0;
    waddr          = widx;
    wdata          = rdata;
    raddr          = '0;

    case (state)
      tsr_pkg::S_IDLE: begin
        if (start) begin
          key_next = tag;
          case (tsr_pkg::func_t'(func))
            tsr_pkg::FUNC_PUSH: begin
              done_next    = 1'b1;
              out_tag_next = '0;
              if (count == CW'(DEPTH)) begin
                status_next = tsr_pkg::ST_FULL;
              end else begin
                we          = 1'b1;
                waddr       = count[AW-1:0];
                wdata       = tag;
                count_next  = count + CW'(1);
                status_next = tsr_pkg::ST_OK;
              end
            end
            tsr_pkg::FUNC_POP: begin
              if (count == '0) begin
                done_next    = 1'b1;
                status_next  = tsr_pkg::ST_EMPTY;
                out_tag_next = '0;
              end else begin
                raddr      = count_dn[AW-1:0];
                count_next = count_dn;
                state_next = tsr_pkg::S_POP;
              end
            end
            tsr_pkg::FUNC_REMOVE: begin
              if (count == '0) begin
                done_next    = 1'b1;
                status_next  = tsr_pkg::ST_EMPTY;
                out_tag_next = '0;
              end else begin
                raddr      = count_dn[AW-1:0];
                ridx_next  = count_dn[AW-1:0];
                state_next = tsr_pkg::S_SEARCH;
              end
            end
            default: begin
              done_next    = 1'b1;
              status_next  = tsr_pkg::ST_OK;
              out_tag_next = '0;
            end
          endcase
        end
      end

      tsr_pkg::S_POP: begin
        done_next    = 1'b1;
        status_next  = tsr_pkg::ST_OK;
        out_tag_next = rdata;
        state_next   = tsr_pkg::S_IDLE;
      end

      tsr_pkg::S_SEARCH: begin
        if (rdata == key) begin
          out_tag_next = rdata;
          if (ridx_up == count) begin
            count_next  = count_dn;
            done_next   = 1'b1;
            status_next = tsr_pkg::ST_OK;
            state_next  = tsr_pkg::S_IDLE;
          end else begin
            raddr      = ridx_up[AW-1:0];
            widx_next  = ridx;
            state_next = tsr_pkg::S_SHIFT;
          end
        end else if (ridx == '0) begin
          done_next    = 1'b1;
          status_next  = tsr_pkg::ST_NOT_FOUND;
          out_tag_next = '0;
          state_next   = tsr_pkg::S_IDLE;
        end else begin
          raddr     = ridx - AW'(1);
          ridx_next = ridx - AW'(1);
        end
      end

      tsr_pkg::S_SHIFT: begin
        // move the entry above down into the gap
        we    = 1'b1;
        waddr = widx;
        wdata = rdata;
        if (widx_up2 == count) begin
          count_next  = count_dn;
          done_next   = 1'b1;
          status_next = tsr_pkg::ST_OK;
          state_next  = tsr_pkg::S_IDLE;
        end else begin
          raddr     = widx_up2[AW-1:0];
          widx_next = widx + AW'(1);
        end
      end

      default: begin
        state_next = tsr_pkg::S_IDLE;
      end
    endcase

    if (done_next) begin
      depth_now_next = count_next;
    end
  end

endmodule

// File: verif/tb_tag_stack_with_remove_top.sv
module tb_tag_stack_with_remove_top;
  import tsr_pkg::*;

  localparam int DEPTH       = 64;
  localparam int TAG_W       = 16;
  localparam int CNT_W       = $clog2(DEPTH + 1);
  localparam int QUIET_LIMIT = 4 * DEPTH + 400;
  localparam int RANDOM_ITEMS = 900;

  typedef struct {
    status_t          st;
    logic [TAG_W-1:0] tg;
    logic [CNT_W-1:0] dp;
  } stack_result_t;

  class tag_stack_scoreboard;
    logic [TAG_W-1:0] slots [DEPTH];
    int               fill;
    stack_result_t    due_results [$];
    int               errors;

    function new();
      fill   = 0;
      errors = 0;
    endfunction

    task report(input string msg);
      errors++;
      $display("MISMATCH: %s", msg);
    endtask

    function void note_command(input func_t op, input logic [TAG_W-1:0] key);
      stack_result_t r;
      int i;
      int k;
      r.st = ST_OK;
      r.tg = '0;
      case (op)
        FUNC_PUSH: begin
          if (fill >= DEPTH) r.st = ST_FULL;
          else begin
            slots[fill] = key;
            fill++;
          end
        end
        FUNC_POP: begin
          if (fill == 0) r.st = ST_EMPTY;
          else begin
            fill--;
            r.tg = slots[fill];
          end
        end
        FUNC_REMOVE: begin
          if (fill == 0) r.st = ST_EMPTY;
          else begin
            i = fill;
            while (i > 0 && slots[i-1] != key) i--;
            if (i == 0) r.st = ST_NOT_FOUND;
            else begin
              i--;
              r.tg = slots[i];
              for (k = i; k + 1 < fill; k++) slots[k] = slots[k+1];
              fill--;
            end
          end
        end
        default: ;
      endcase
      r.dp = CNT_W'(fill);
      due_results.push_back(r);
    endfunction

    task check_result(input status_t st, input logic [TAG_W-1:0] tg,
                      input logic [CNT_W-1:0] dp);
      stack_result_t e;
      if (due_results.size() == 0) begin
        report($sformatf("result with none due: status %0d tag %h depth %0d",
                         st, tg, dp));
      end else begin
        e = due_results.pop_front();
        if (st !== e.st)
          report($sformatf("status %0d, expected %0d", st, e.st));
        if (tg !== e.tg)
          report($sformatf("out_tag %h, expected %h", tg, e.tg));
        if (dp !== e.dp)
          report($sformatf("depth_now %0d, expected %0d", dp, e.dp));
      end
    endtask

    function logic [TAG_W-1:0] stored_tag();
      if (fill == 0) return TAG_W'($urandom);
      return slots[$urandom_range(0, fill - 1)];
    endfunction

    function int outstanding();
      return due_results.size();
    endfunction
  endclass

  logic             clk   = 1'b0;
  logic             rst   = 1'b1;
  logic             start = 1'b0;
  logic [1:0]       func  = 2'd0;
  logic [TAG_W-1:0] tag   = '0;
  logic             busy;
  logic             done;
  logic [1:0]       status;
  logic [TAG_W-1:0] out_tag;
  logic [CNT_W-1:0] depth_now;

  tag_stack_scoreboard board;
  int                  burst_left = 0;
  int                  quiet_cycles = 0;

  always #5 clk = ~clk;

  tag_stack_with_remove_top #(
    .DEPTH    (DEPTH),
    .TAG_BITS (TAG_W)
  ) dut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .func      (func),
    .tag       (tag),
    .done      (done),
    .status    (status),
    .out_tag   (out_tag),
    .depth_now (depth_now)
  );

  always @(posedge clk) begin
    if (!rst && done) board.check_result(status_t'(status), out_tag, depth_now);
  end

  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic issue(input func_t op, input logic [TAG_W-1:0] key);
    int gap;
    start <= 1'b1;
    func  <= op;
    tag   <= key;
    do @(posedge clk); while (busy);
    board.note_command(op, key);
    if (burst_left > 0) burst_left--;
    else begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 80)
                                               : $urandom_range(0, 15);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        func  <= 2'($urandom);
        tag   <= TAG_W'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
  endtask

  function automatic logic [TAG_W-1:0] pool_tag();
    logic [TAG_W-1:0] pool [8];
    pool = '{16'h0000, 16'hFFFF, 16'h8000, 16'h0001,
             16'h5555, 16'hAAAA, 16'h1234, 16'hBEEF};
    return pool[$urandom_range(0, 7)];
  endfunction

  initial begin
    int issued;
    int mode;
    int len;
    int roll;
    func_t op;
    logic [TAG_W-1:0] key;

    board = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    issue(FUNC_POP, 16'h0000);
    issue(FUNC_REMOVE, 16'h0000);
    issue(FUNC_NONE, 16'hFFFF);
    issue(FUNC_PUSH, 16'h0000);
    issue(FUNC_PUSH, 16'hFFFF);
    issue(FUNC_PUSH, 16'hA5A5);
    issue(FUNC_PUSH, 16'h5A5A);
    issue(FUNC_PUSH, 16'hA5A5);
    issue(FUNC_REMOVE, 16'hA5A5);
    issue(FUNC_REMOVE, 16'h1234);
    issue(FUNC_REMOVE, 16'h0000);
    issue(FUNC_NONE, 16'h5A5A);
    issue(FUNC_POP, 16'h0000);
    issue(FUNC_POP, 16'h0000);
    issue(FUNC_POP, 16'h0000);
    issue(FUNC_POP, 16'h0000);
    issue(FUNC_PUSH, 16'h8000);
    issue(FUNC_PUSH, 16'h0001);
    issue(FUNC_REMOVE, 16'h8000);
    issue(FUNC_POP, 16'h0000);
    issue(FUNC_REMOVE, 16'hFFFF);

    // open with a fill phase long enough to reach full
    issued = 0;
    mode   = 0;
    len    = 90;
    while (issued < RANDOM_ITEMS) begin
      repeat (len) begin
        if (issued >= RANDOM_ITEMS) break;
        roll = $urandom_range(0, 99);
        if (roll < 3) op = FUNC_NONE;
        else if ((mode == 0 && roll < 92) || (mode == 1 && roll < 12) ||
                 (mode == 2 && roll < 48)) op = FUNC_PUSH;
        else if ($urandom_range(0, 9) < 4) op = FUNC_POP;
        else op = FUNC_REMOVE;

        roll = $urandom_range(0, 99);
        if (op == FUNC_REMOVE)
          key = (roll < 65) ? board.stored_tag() :
                (roll < 80) ? pool_tag() : TAG_W'($urandom);
        else
          key = (roll < 40) ? pool_tag() : TAG_W'($urandom);

        issue(op, key);
        issued++;
      end
      mode = $urandom_range(0, 2);
      len  = $urandom_range(20, 120);
    end

    start <= 1'b0;
    while (board.outstanding() != 0) @(posedge clk);
    repeat (2 * DEPTH + 8) @(posedge clk);

    if (board.errors == 0 && board.outstanding() == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/tsr_pkg.sv
hdl/tsr_ram.sv
hdl/tag_stack_with_remove_top.sv
verif/tb_tag_stack_with_remove_top.sv
